// File: rtl/gpf_pkg.sv
// gravity pair force: shared constants and the result status codes
// no dependencies; used through scoped names by the top level and the testbench

package gpf_pkg;

   // default geometry of the positions and of the force
   localparam int COORD_WIDTH_DEFAULT   = 32;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // fixed field widths
   localparam int MASS_WIDTH   = 32;
   localparam int GRAV_WIDTH   = 32;
   localparam int FORCE_WIDTH  = 48;
   localparam int STATUS_WIDTH = 2;

   // extra fraction bits carried by the distance root
   localparam int SQRT_EXTRA = 16;

   // scale of the gravitational constant (value times 2^-GRAV_SCALE)
   localparam int GRAV_SCALE = 32;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_COINCIDENT = 2'd1,
      STATUS_SATURATED  = 2'd2
   } status_type;

endpackage

// File: rtl/gravity_pair_force.sv
// gravity pair force: top level, force on one body from a second body
// depends on gpf_pkg, gpf_mul_chain, gpf_sqrt_chain and gpf_div_chain
//
// Usage
//   Input: a body pair is taken on each rising edge with start high and busy
//   low. busy is high while reset is applied and for the first cycle after
//   it, so from then on a pair can be given on every cycle.
//   Output: one result per pair, in order, on the rsp_ ports for one cycle
//   with rsp_valid high. The receiver cannot stall; nothing is held back.
//   Pipeline: entry register, squaring row, sum register, root row, rows
//   for distance squared, distance cubed, mass product and numerators,
//   divider check cell and quotient row, output register; each row has one
//   cell per multiplier bit, root bit or quotient bit. Throughput one pair
//   per cycle. Configuration: the gravitational constant is written through
//   csr_ while no pair is in flight; the user must keep to this, the block
//   does not enforce it. csr_ready is always high.
//   Reset clears the constant to zero and empties the pipeline.
//   status: ok, coincident bodies (force zero) or saturated component.

module gravity_pair_force #(
   parameter int COORD_WIDTH   = gpf_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = gpf_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [COORD_WIDTH-1:0]           req_self_x,
   input  logic signed [COORD_WIDTH-1:0]           req_self_y,
   input  logic signed [COORD_WIDTH-1:0]           req_self_z,
   input  logic [gpf_pkg::MASS_WIDTH-1:0]          req_self_mass,
   input  logic signed [COORD_WIDTH-1:0]           req_other_x,
   input  logic signed [COORD_WIDTH-1:0]           req_other_y,
   input  logic signed [COORD_WIDTH-1:0]           req_other_z,
   input  logic [gpf_pkg::MASS_WIDTH-1:0]          req_other_mass,
   output logic                                    rsp_valid,
   output logic signed [gpf_pkg::FORCE_WIDTH-1:0]  rsp_force_x,
   output logic signed [gpf_pkg::FORCE_WIDTH-1:0]  rsp_force_y,
   output logic signed [gpf_pkg::FORCE_WIDTH-1:0]  rsp_force_z,
   output logic [gpf_pkg::STATUS_WIDTH-1:0]        rsp_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [gpf_pkg::GRAV_WIDTH-1:0]          csr_data
);

   localparam int MASS_W    = gpf_pkg::MASS_WIDTH;
   localparam int GRAV_W    = gpf_pkg::GRAV_WIDTH;
   localparam int FORCE_W   = gpf_pkg::FORCE_WIDTH;
   localparam int SE        = gpf_pkg::SQRT_EXTRA;
   localparam int MAG_W     = COORD_WIDTH + 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_IN_W = 2 * ((SUM_W + 2 * SE + 1) / 2);
   localparam int ROOT_W    = ROOT_IN_W / 2;
   localparam int SQ2_W     = 2 * ROOT_W;
   localparam int CUBE_W    = 3 * ROOT_W;
   localparam int GM_W      = GRAV_W + MASS_W;
   localparam int K_W       = GM_W + MASS_W;
   localparam int PROD_W    = K_W + MAG_W;
   localparam int NUM_SHIFT = FRACTION_BITS + 3 * SE - gpf_pkg::GRAV_SCALE;
   localparam int NUM_W     = PROD_W + NUM_SHIFT;

   localparam int SIDE1_W = 3 + 3 * MAG_W + GM_W + MASS_W;
   localparam int SIDE2_W = 1 + SIDE1_W;
   localparam int SIDE3_W = ROOT_W + SIDE2_W;
   localparam int SIDE5_W = CUBE_W + 1 + 3 + 3 * MAG_W;
   localparam int SIDE6_W = CUBE_W + 1 + 3;
   localparam int SIDE7_W = 1 + 3;

   localparam logic [FORCE_W-1:0] POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
   localparam logic [FORCE_W-1:0] NEG_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

   // configuration and handshake
   logic              busy_ff;
   logic [GRAV_W-1:0] grav_ff;
   logic              accept;

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         grav_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            grav_ff <= csr_data;
         end
      end
   end

   // entry stage: separation per axis and first mass product
   logic signed [COORD_WIDTH-1:0] self_pos  [3];
   logic signed [COORD_WIDTH-1:0] other_pos [3];
   logic signed [MAG_W-1:0]       diff      [3];
   logic [2:0][MAG_W-1:0]         mag_in;
   logic [2:0]                    neg_in;
   logic [GM_W-1:0]               gm_in;

   logic                  valid0_ff;
   logic [2:0][MAG_W-1:0] mag0_ff;
   logic [2:0]            neg0_ff;
   logic [GM_W-1:0]       gm0_ff;
   logic [MASS_W-1:0]     m20_ff;

   assign self_pos[0]  = req_self_x;
   assign self_pos[1]  = req_self_y;
   assign self_pos[2]  = req_self_z;
   assign other_pos[0] = req_other_x;
   assign other_pos[1] = req_other_y;
   assign other_pos[2] = req_other_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]   = MAG_W'(other_pos[i]) - MAG_W'(self_pos[i]);
         neg_in[i] = diff[i][MAG_W-1];
         mag_in[i] = neg_in[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      end
      gm_in = GM_W'(grav_ff) * GM_W'(req_self_mass);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      mag0_ff <= mag_in;
      neg0_ff <= neg_in;
      gm0_ff  <= gm_in;
      m20_ff  <= req_other_mass;
   end

   // squares of the separations
   logic                  sq_valid;
   logic [2:0][SQ_W-1:0]  sq_p;
   logic [SIDE1_W-1:0]    sq_side;

   gpf_mul_chain #(
      .LANES      (3),
      .A_WIDTH    (MAG_W),
      .B_WIDTH    (MAG_W),
      .SIDE_WIDTH (SIDE1_W)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid0_ff),
      .in_a      (mag0_ff),
      .in_b      (mag0_ff),
      .in_side   ({neg0_ff, mag0_ff, gm0_ff, m20_ff}),
      .out_valid (sq_valid),
      .out_p     (sq_p),
      .out_side  (sq_side)
   );

   // squared distance and coincidence test
   logic [SUM_W-1:0]   sum_in;
   logic               valid1_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               zero_ff;
   logic [SIDE1_W-1:0] side1_ff;

   assign sum_in = SUM_W'(sq_p[0]) + SUM_W'(sq_p[1]) + SUM_W'(sq_p[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      zero_ff  <= (sum_in == '0);
      side1_ff <= sq_side;
   end

   // distance with extra fraction bits
   logic               rt_valid;
   logic [ROOT_W-1:0]  rt_root;
   logic [SIDE2_W-1:0] rt_side;

   gpf_sqrt_chain #(
      .IN_WIDTH   (ROOT_IN_W),
      .SIDE_WIDTH (SIDE2_W)
   ) u_root (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (valid1_ff),
      .in_radicand (ROOT_IN_W'(sum_ff) << (2 * SE)),
      .in_side     ({zero_ff, side1_ff}),
      .out_valid   (rt_valid),
      .out_root    (rt_root),
      .out_side    (rt_side)
   );

   // distance squared
   logic               l2_valid;
   logic [SQ2_W-1:0]   l2_p;
   logic [SIDE3_W-1:0] l2_side;
   logic [ROOT_W-1:0]  root3;
   logic [SIDE2_W-1:0] side3;

   gpf_mul_chain #(
      .LANES      (1),
      .A_WIDTH    (ROOT_W),
      .B_WIDTH    (ROOT_W),
      .SIDE_WIDTH (SIDE3_W)
   ) u_dist_sq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_a      (rt_root),
      .in_b      (rt_root),
      .in_side   ({rt_root, rt_side}),
      .out_valid (l2_valid),
      .out_p     (l2_p),
      .out_side  (l2_side)
   );

   assign {root3, side3} = l2_side;

   // distance cubed
   logic               l3_valid;
   logic [CUBE_W-1:0]  l3_p;
   logic [SIDE2_W-1:0] l3_side;
   logic               zero4;
   logic [2:0]         neg4;
   logic [2:0][MAG_W-1:0] mag4;
   logic [GM_W-1:0]    gm4;
   logic [MASS_W-1:0]  m24;

   gpf_mul_chain #(
      .LANES      (1),
      .A_WIDTH    (SQ2_W),
      .B_WIDTH    (ROOT_W),
      .SIDE_WIDTH (SIDE2_W)
   ) u_dist_cube (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l2_valid),
      .in_a      (l2_p),
      .in_b      (root3),
      .in_side   (side3),
      .out_valid (l3_valid),
      .out_p     (l3_p),
      .out_side  (l3_side)
   );

   assign {zero4, neg4, mag4, gm4, m24} = l3_side;

   // full mass and gravity product
   logic                  k_valid;
   logic [K_W-1:0]        k_p;
   logic [SIDE5_W-1:0]    k_side;
   logic [CUBE_W-1:0]     cube5;
   logic                  zero5;
   logic [2:0]            neg5;
   logic [2:0][MAG_W-1:0] mag5;

   gpf_mul_chain #(
      .LANES      (1),
      .A_WIDTH    (GM_W),
      .B_WIDTH    (MASS_W),
      .SIDE_WIDTH (SIDE5_W)
   ) u_mass (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l3_valid),
      .in_a      (gm4),
      .in_b      (m24),
      .in_side   ({l3_p, zero4, neg4, mag4}),
      .out_valid (k_valid),
      .out_p     (k_p),
      .out_side  (k_side)
   );

   assign {cube5, zero5, neg5, mag5} = k_side;

   // numerator per axis
   logic                   n_valid;
   logic [2:0][PROD_W-1:0] n_p;
   logic [SIDE6_W-1:0]     n_side;
   logic [CUBE_W-1:0]      cube6;
   logic                   zero6;
   logic [2:0]             neg6;
   logic [2:0][NUM_W-1:0]  num6;

   gpf_mul_chain #(
      .LANES      (3),
      .A_WIDTH    (K_W),
      .B_WIDTH    (MAG_W),
      .SIDE_WIDTH (SIDE6_W)
   ) u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (k_valid),
      .in_a      ({3{k_p}}),
      .in_b      (mag5),
      .in_side   ({cube5, zero5, neg5}),
      .out_valid (n_valid),
      .out_p     (n_p),
      .out_side  (n_side)
   );

   assign {cube6, zero6, neg6} = n_side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num6[i] = NUM_W'(n_p[i]) << NUM_SHIFT;
      end
   end

   // force magnitudes
   logic                    div_valid;
   logic [2:0][FORCE_W-1:0] div_quo;
   logic [2:0]              div_ovf;
   logic [SIDE7_W-1:0]      div_side;
   logic                    zero7;
   logic [2:0]              neg7;

   gpf_div_chain #(
      .LANES      (3),
      .NUM_WIDTH  (NUM_W),
      .DEN_WIDTH  (CUBE_W),
      .QUO_WIDTH  (FORCE_W),
      .SIDE_WIDTH (SIDE7_W)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_valid),
      .in_num    (num6),
      .in_den    (cube6),
      .in_side   ({zero6, neg6}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_ovf   (div_ovf),
      .out_side  (div_side)
   );

   assign {zero7, neg7} = div_side;

   // saturation, sign and status
   logic [FORCE_W-1:0]      limit   [3];
   logic [FORCE_W-1:0]      clipped [3];
   logic [2:0][FORCE_W-1:0] force_in;
   logic [2:0]              sat;
   gpf_pkg::status_type     status_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         limit[i]   = neg7[i] ? NEG_MIN : POS_MAX;
         sat[i]     = div_ovf[i] || (div_quo[i] > limit[i]);
         clipped[i] = sat[i] ? limit[i] : div_quo[i];
         force_in[i] = neg7[i] ? FORCE_W'(-clipped[i]) : clipped[i];
      end
      if (zero7) begin
         force_in  = '0;
         status_in = gpf_pkg::STATUS_COINCIDENT;
      end else if (sat != 3'b000) begin
         status_in = gpf_pkg::STATUS_SATURATED;
      end else begin
         status_in = gpf_pkg::STATUS_OK;
      end
   end

   logic                    rsp_valid_ff;
   logic [2:0][FORCE_W-1:0] force_ff;
   gpf_pkg::status_type     status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      force_ff  <= force_in;
      status_ff <= status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_force_x = force_ff[0];
   assign rsp_force_y = force_ff[1];
   assign rsp_force_z = force_ff[2];
   assign rsp_status  = status_ff;

   // coincident bodies never carry a force
   a_coincident_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == gpf_pkg::STATUS_COINCIDENT) |->
      (rsp_force_x == '0 && rsp_force_y == '0 && rsp_force_z == '0))
      else $error("coincident result with non-zero force");

   // a saturated result has at least one component at a rail
   a_saturated_rail : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == gpf_pkg::STATUS_SATURATED) |->
      (rsp_force_x == POS_MAX || rsp_force_x == NEG_MIN ||
       rsp_force_y == POS_MAX || rsp_force_y == NEG_MIN ||
       rsp_force_z == POS_MAX || rsp_force_z == NEG_MIN))
      else $error("saturated status without a clipped component");

   // each result transfer comes from a finished division
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(div_valid))
      else $error("result without a division behind it");

endmodule

// File: rtl/gpf_mul_chain.sv
// gravity pair force: shift-and-add multiplier built as a row of cells,
// one multiplier bit per cell, with sideband data travelling alongside
// no package dependencies

module gpf_mul_chain #(
   parameter int LANES      = 1,
   parameter int A_WIDTH    = 8,
   parameter int B_WIDTH    = 8,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [LANES-1:0][A_WIDTH-1:0]         in_a,
   input  logic [LANES-1:0][B_WIDTH-1:0]         in_b,
   input  logic [SIDE_WIDTH-1:0]                in_side,
   output logic                                 out_valid,
   output logic [LANES-1:0][A_WIDTH+B_WIDTH-1:0] out_p,
   output logic [SIDE_WIDTH-1:0]                out_side
);

   localparam int P_WIDTH = A_WIDTH + B_WIDTH;

   logic                          valid_ff [B_WIDTH];
   logic [LANES-1:0][A_WIDTH-1:0] a_ff     [B_WIDTH];
   logic [LANES-1:0][B_WIDTH-1:0] b_ff     [B_WIDTH];
   logic [LANES-1:0][P_WIDTH-1:0] acc_ff   [B_WIDTH];
   logic [SIDE_WIDTH-1:0]         side_ff  [B_WIDTH];

   for (genvar k = 0; k < B_WIDTH; k++) begin : g_cell
      logic                          valid_prev;
      logic [LANES-1:0][A_WIDTH-1:0] a_prev;
      logic [LANES-1:0][B_WIDTH-1:0] b_prev;
      logic [LANES-1:0][P_WIDTH-1:0] acc_prev;
      logic [SIDE_WIDTH-1:0]         side_prev;
      logic [LANES-1:0][P_WIDTH-1:0] acc_in;

      // neighbour hand-over
      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign a_prev     = in_a;
         assign b_prev     = in_b;
         assign acc_prev   = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign a_prev     = a_ff[k-1];
         assign b_prev     = b_ff[k-1];
         assign acc_prev   = acc_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // add the shifted multiplicand when this cell's bit is set
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            acc_in[l] = acc_prev[l];
            if (b_prev[l][k]) begin
               acc_in[l] = acc_prev[l] + (P_WIDTH'(a_prev[l]) << k);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         a_ff[k]    <= a_prev;
         b_ff[k]    <= b_prev;
         acc_ff[k]  <= acc_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[B_WIDTH-1];
   assign out_p     = acc_ff[B_WIDTH-1];
   assign out_side  = side_ff[B_WIDTH-1];

endmodule

// File: rtl/gpf_sqrt_chain.sv
// gravity pair force: integer square root as a row of cells, one root bit
// per cell (restoring digit-by-digit method), sideband data alongside
// no package dependencies

module gpf_sqrt_chain #(
   parameter int IN_WIDTH   = 16,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [IN_WIDTH-1:0]     in_radicand,
   input  logic [SIDE_WIDTH-1:0]   in_side,
   output logic                    out_valid,
   output logic [IN_WIDTH/2-1:0]   out_root,
   output logic [SIDE_WIDTH-1:0]   out_side
);

   localparam int ROOT_WIDTH = IN_WIDTH / 2;

   logic                  valid_ff [ROOT_WIDTH];
   logic [IN_WIDTH-1:0]   op_ff    [ROOT_WIDTH];
   logic [IN_WIDTH-1:0]   res_ff   [ROOT_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff  [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_cell
      localparam logic [IN_WIDTH-1:0] ONE = IN_WIDTH'(1) << (IN_WIDTH - 2 - 2 * k);

      logic                  valid_prev;
      logic [IN_WIDTH-1:0]   op_prev;
      logic [IN_WIDTH-1:0]   res_prev;
      logic [SIDE_WIDTH-1:0] side_prev;
      logic [IN_WIDTH-1:0]   trial;
      logic [IN_WIDTH-1:0]   op_in;
      logic [IN_WIDTH-1:0]   res_in;

      // neighbour hand-over
      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign op_prev    = in_radicand;
         assign res_prev   = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign op_prev    = op_ff[k-1];
         assign res_prev   = res_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // try this root bit, keep it when the remainder allows
      always_comb begin
         trial = res_prev + ONE;
         if (op_prev >= trial) begin
            op_in  = op_prev - trial;
            res_in = (res_prev >> 1) + ONE;
         end else begin
            op_in  = op_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         op_ff[k]   <= op_in;
         res_ff[k]  <= res_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[ROOT_WIDTH-1];
   assign out_root  = res_ff[ROOT_WIDTH-1][ROOT_WIDTH-1:0];
   assign out_side  = side_ff[ROOT_WIDTH-1];

endmodule

// File: rtl/gpf_div_chain.sv
// gravity pair force: restoring divider as a row of cells, one quotient bit
// per cell after an overflow check cell; lanes share the divisor
// no package dependencies

module gpf_div_chain #(
   parameter int LANES      = 1,
   parameter int NUM_WIDTH  = 16,
   parameter int DEN_WIDTH  = 8,
   parameter int QUO_WIDTH  = 8,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [LANES-1:0][NUM_WIDTH-1:0]      in_num,
   input  logic [DEN_WIDTH-1:0]                in_den,
   input  logic [SIDE_WIDTH-1:0]               in_side,
   output logic                                out_valid,
   output logic [LANES-1:0][QUO_WIDTH-1:0]      out_quo,
   output logic [LANES-1:0]                    out_ovf,
   output logic [SIDE_WIDTH-1:0]               out_side
);

   localparam int REM_WIDTH = (NUM_WIDTH > DEN_WIDTH + QUO_WIDTH) ?
                              NUM_WIDTH : DEN_WIDTH + QUO_WIDTH;

   // overflow check cell
   logic                            chk_valid_ff;
   logic [LANES-1:0][REM_WIDTH-1:0] chk_rem_ff;
   logic [LANES-1:0]                chk_ovf_ff;
   logic [DEN_WIDTH-1:0]            chk_den_ff;
   logic [SIDE_WIDTH-1:0]           chk_side_ff;
   logic [LANES-1:0][REM_WIDTH-1:0] chk_rem_in;
   logic [LANES-1:0]                chk_ovf_in;

   // quotient cells
   logic                            valid_ff [QUO_WIDTH];
   logic [LANES-1:0][REM_WIDTH-1:0] rem_ff   [QUO_WIDTH];
   logic [LANES-1:0][QUO_WIDTH-1:0] quo_ff   [QUO_WIDTH];
   logic [LANES-1:0]                ovf_ff   [QUO_WIDTH];
   logic [DEN_WIDTH-1:0]            den_ff   [QUO_WIDTH];
   logic [SIDE_WIDTH-1:0]           side_ff  [QUO_WIDTH];

   // quotient would not fit: numerator at or above divisor times 2^QUO_WIDTH
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         chk_rem_in[l] = REM_WIDTH'(in_num[l]);
         chk_ovf_in[l] = chk_rem_in[l] >= (REM_WIDTH'(in_den) << QUO_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
      end else begin
         chk_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      chk_rem_ff  <= chk_rem_in;
      chk_ovf_ff  <= chk_ovf_in;
      chk_den_ff  <= in_den;
      chk_side_ff <= in_side;
   end

   for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_cell
      localparam int BIT = QUO_WIDTH - 1 - k;

      logic                            valid_prev;
      logic [LANES-1:0][REM_WIDTH-1:0] rem_prev;
      logic [LANES-1:0][QUO_WIDTH-1:0] quo_prev;
      logic [LANES-1:0]                ovf_prev;
      logic [DEN_WIDTH-1:0]            den_prev;
      logic [SIDE_WIDTH-1:0]           side_prev;
      logic [REM_WIDTH-1:0]            den_shift;
      logic [LANES-1:0][REM_WIDTH-1:0] rem_in;
      logic [LANES-1:0][QUO_WIDTH-1:0] quo_in;

      // neighbour hand-over
      if (k == 0) begin : g_first
         assign valid_prev = chk_valid_ff;
         assign rem_prev   = chk_rem_ff;
         assign quo_prev   = '0;
         assign ovf_prev   = chk_ovf_ff;
         assign den_prev   = chk_den_ff;
         assign side_prev  = chk_side_ff;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign ovf_prev   = ovf_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // subtract the aligned divisor where it fits and set the quotient bit
      always_comb begin
         den_shift = REM_WIDTH'(den_prev) << BIT;
         for (int l = 0; l < LANES; l++) begin
            rem_in[l] = rem_prev[l];
            quo_in[l] = quo_prev[l];
            if (rem_prev[l] >= den_shift) begin
               rem_in[l]      = rem_prev[l] - den_shift;
               quo_in[l][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         quo_ff[k]  <= quo_in;
         ovf_ff[k]  <= ovf_prev;
         den_ff[k]  <= den_prev;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[QUO_WIDTH-1];
   assign out_quo   = quo_ff[QUO_WIDTH-1];
   assign out_ovf   = ovf_ff[QUO_WIDTH-1];
   assign out_side  = side_ff[QUO_WIDTH-1];

endmodule

// File: tb/gravity_pair_force_test.sv
// gravity pair force testbench: driver, monitor and a wide-integer force predictor
// depends on gpf_pkg and gravity_pair_force from the rtl folder
`timescale 1ns / 1ps

module gravity_pair_force_test;

   localparam int CW = gpf_pkg::COORD_WIDTH_DEFAULT;
   localparam int FB = gpf_pkg::FRACTION_BITS_DEFAULT;
   localparam int MW = gpf_pkg::MASS_WIDTH;
   localparam int FW = gpf_pkg::FORCE_WIDTH;
   localparam int GW = gpf_pkg::GRAV_WIDTH;
   localparam int SE = gpf_pkg::SQRT_EXTRA;
   localparam int SETTLE_CYCLES = 320;

   typedef struct {
      logic signed [CW-1:0] self_pos[3];
      logic signed [CW-1:0] other_pos[3];
      logic [MW-1:0]        self_mass;
      logic [MW-1:0]        other_mass;
   } body_pair_type;

   typedef struct {
      logic signed [FW-1:0] force_xyz[3];
      gpf_pkg::status_type  status;
   } force_result_type;

   logic clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   logic signed [CW-1:0] req_self_x, req_self_y, req_self_z;
   logic signed [CW-1:0] req_other_x, req_other_y, req_other_z;
   logic [MW-1:0] req_self_mass, req_other_mass;
   logic signed [FW-1:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic [gpf_pkg::STATUS_WIDTH-1:0] rsp_status;
   logic [GW-1:0] csr_data;

   body_pair_type    pending_pairs[$];
   force_result_type expected_forces[$];
   logic [GW-1:0] grav_model;
   logic took;
   bit   burst;
   int   gap_left;
   int   mismatches, pairs_sent, forces_checked, n_sat, n_coinc;

   gravity_pair_force u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_self_x(req_self_x), .req_self_y(req_self_y), .req_self_z(req_self_z),
      .req_self_mass(req_self_mass),
      .req_other_x(req_other_x), .req_other_y(req_other_y), .req_other_z(req_other_z),
      .req_other_mass(req_other_mass),
      .rsp_valid(rsp_valid), .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_force_z(rsp_force_z), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // exact force: G*m1*m2*|d|*2^(FB+3E) / (L^3*2^32), truncated, then saturated
   function automatic force_result_type predict_force(body_pair_type p, logic [GW-1:0] g);
      logic [255:0] dist_sq, root, trial, den, k, quot, limit;
      logic [255:0] mag[3];
      logic signed [CW:0] d;
      logic neg[3];
      logic sat;
      force_result_type r;
      dist_sq = '0;
      for (int i = 0; i < 3; i++) begin
         d = {p.other_pos[i][CW-1], p.other_pos[i]} - {p.self_pos[i][CW-1], p.self_pos[i]};
         neg[i] = d[CW];
         mag[i] = '0;
         mag[i][CW:0] = neg[i] ? -d : d;
         dist_sq = dist_sq + mag[i] * mag[i];
      end
      if (dist_sq == 0) begin
         for (int i = 0; i < 3; i++) r.force_xyz[i] = '0;
         r.status = gpf_pkg::STATUS_COINCIDENT;
         return r;
      end
      dist_sq = dist_sq << (2 * SE);
      root = '0;
      for (int b = 69; b >= 0; b--) begin
         trial = root;
         trial[b] = 1'b1;
         if (trial * trial <= dist_sq) root = trial;
      end
      den = (root * root * root) << gpf_pkg::GRAV_SCALE;
      k = ((256'(g) * 256'(p.self_mass)) * 256'(p.other_mass)) << (FB + 3 * SE);
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         quot = (k * mag[i]) / den;
         limit = neg[i] ? (256'(1) << (FW - 1)) : (256'(1) << (FW - 1)) - 1;
         if (quot > limit) begin
            quot = limit;
            sat = 1'b1;
         end
         r.force_xyz[i] = neg[i] ? -quot[FW-1:0] : quot[FW-1:0];
      end
      r.status = sat ? gpf_pkg::STATUS_SATURATED : gpf_pkg::STATUS_OK;
      return r;
   endfunction

   // driver: one pair in flight on the req_ ports, random gaps after each transfer
   always @(negedge clock) begin
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start;
         if (start && took) begin
            void'(pending_pairs.pop_front());
            go = 1'b0;
            if ($urandom_range(0, 15) == 0) burst = !burst;
            gap_left = burst ? 0 : $urandom_range(0, 17);
         end
         if (!go) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pairs.size() > 0) begin
               go = 1'b1;
               req_self_x     <= pending_pairs[0].self_pos[0];
               req_self_y     <= pending_pairs[0].self_pos[1];
               req_self_z     <= pending_pairs[0].self_pos[2];
               req_other_x    <= pending_pairs[0].other_pos[0];
               req_other_y    <= pending_pairs[0].other_pos[1];
               req_other_z    <= pending_pairs[0].other_pos[2];
               req_self_mass  <= pending_pairs[0].self_mass;
               req_other_mass <= pending_pairs[0].other_mass;
            end
         end
         start <= go;
      end
   end

   // monitor: predict on each input transfer, check each result, track the constant
   always @(posedge clock) begin
      body_pair_type p;
      force_result_type want;
      logic signed [FW-1:0] got[3];
      took <= !reset && start && !busy;
      if (reset) begin
         grav_model <= '0;
      end else begin
         if (csr_valid && csr_ready) grav_model <= csr_data;
         if (start && !busy) begin
            p.self_pos[0] = req_self_x;
            p.self_pos[1] = req_self_y;
            p.self_pos[2] = req_self_z;
            p.other_pos[0] = req_other_x;
            p.other_pos[1] = req_other_y;
            p.other_pos[2] = req_other_z;
            p.self_mass = req_self_mass;
            p.other_mass = req_other_mass;
            expected_forces.push_back(predict_force(p, grav_model));
            pairs_sent++;
         end
         if (rsp_valid) begin
            got[0] = rsp_force_x;
            got[1] = rsp_force_y;
            got[2] = rsp_force_z;
            if (expected_forces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: force %0d %0d %0d status %0d",
                           got[0], got[1], got[2], rsp_status);
            end else begin
               want = expected_forces.pop_front();
               forces_checked++;
               if (want.status == gpf_pkg::STATUS_SATURATED) n_sat++;
               if (want.status == gpf_pkg::STATUS_COINCIDENT) n_coinc++;
               if (got[0] !== want.force_xyz[0] || got[1] !== want.force_xyz[1] ||
                   got[2] !== want.force_xyz[2] || rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch on result %0d: exp %0d %0d %0d st %0d, ",
                               "got %0d %0d %0d st %0d"},
                              forces_checked, want.force_xyz[0], want.force_xyz[1],
                              want.force_xyz[2], want.status, got[0], got[1], got[2],
                              rsp_status);
               end
            end
         end
      end
   end

   function automatic body_pair_type make_pair(logic signed [CW-1:0] s0,
                                               logic signed [CW-1:0] s1,
                                               logic signed [CW-1:0] s2,
                                               logic signed [CW-1:0] o0,
                                               logic signed [CW-1:0] o1,
                                               logic signed [CW-1:0] o2,
                                               logic [MW-1:0] m1, logic [MW-1:0] m2);
      body_pair_type p;
      p.self_pos[0] = s0;
      p.self_pos[1] = s1;
      p.self_pos[2] = s2;
      p.other_pos[0] = o0;
      p.other_pos[1] = o1;
      p.other_pos[2] = o2;
      p.self_mass = m1;
      p.other_mass = m2;
      return p;
   endfunction

   // random pair: mostly near neighbours with scaled masses, some full-range noise
   function automatic body_pair_type random_pair();
      body_pair_type p;
      logic signed [CW-1:0] delta;
      bit near_pair;
      near_pair = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 3; i++) begin
         p.self_pos[i] = $urandom;
         delta = $urandom >> $urandom_range(0, 31);
         if ($urandom_range(0, 1)) delta = -delta;
         if ($urandom_range(0, 7) == 0) delta = '0;
         p.other_pos[i] = near_pair ? p.self_pos[i] + delta : $urandom;
      end
      p.self_mass = $urandom >> $urandom_range(0, 31);
      p.other_mass = $urandom >> $urandom_range(0, 31);
      return p;
   endfunction

   task automatic wait_drained();
      do @(posedge clock); while (pending_pairs.size() != 0 || expected_forces.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gravity(logic [GW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   localparam logic signed [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] PMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [MW-1:0] MMAX = '1;
   localparam logic [MW-1:0] ONE_MASS = 32'h0001_0000;

   // stimulus
   initial begin
      logic [GW-1:0] grav_settings[5];
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      took = 1'b0;
      burst = 1'b0;
      gap_left = 0;
      {req_self_x, req_self_y, req_self_z, req_other_x, req_other_y, req_other_z} = '0;
      req_self_mass = '0;
      req_other_mass = '0;
      mismatches = 0;
      pairs_sent = 0;
      forces_checked = 0;
      n_sat = 0;
      n_coinc = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // constant still at its reset value of zero
      pending_pairs.push_back(make_pair(0, 0, 0, 32'h10000, 0, 0, MMAX, MMAX));
      pending_pairs.push_back(make_pair(5, 5, 5, 5, 5, 5, MMAX, MMAX));
      wait_drained();

      // directed: extremes, zero mass, coincident bodies, saturation on each axis
      write_gravity('1);
      pending_pairs.push_back(make_pair(7, -7, 3, 7, -7, 3, ONE_MASS, ONE_MASS));
      pending_pairs.push_back(make_pair(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, MMAX, MMAX));
      pending_pairs.push_back(make_pair(0, 0, 0, 32'h10000, 0, 0, 0, MMAX));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 32'h10000, 0, MMAX, 0));
      pending_pairs.push_back(make_pair(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, MMAX, MMAX));
      pending_pairs.push_back(make_pair(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, MMAX, MMAX));
      pending_pairs.push_back(make_pair(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 1, 1));
      pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0, MMAX, MMAX));
      pending_pairs.push_back(make_pair(0, 0, 0, -1, 0, 0, MMAX, MMAX));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 1, 0, MMAX, MMAX));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, -1, MMAX, MMAX));
      pending_pairs.push_back(make_pair(0, 0, 0, 32'h10000, 0, 0, ONE_MASS, ONE_MASS));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, -32'h10000, 0, ONE_MASS, ONE_MASS));
      pending_pairs.push_back(make_pair(0, 0, 0, 32'h30000, 32'h40000, 0, ONE_MASS, 32'h20000));
      pending_pairs.push_back(make_pair(32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 32'h8000,
                                        32'h3_0000));
      pending_pairs.push_back(make_pair(PMAX, 0, PMIN, PMAX - 100, 50, PMIN + 7, MMAX, 1));
      pending_pairs.push_back(make_pair(-1, -1, -1, 0, 0, 0, 1, MMAX));
      wait_drained();

      // random phases under several constants, draining between them
      grav_settings[0] = 32'd1;
      grav_settings[1] = 32'h0001_0000;
      grav_settings[2] = $urandom;
      grav_settings[3] = 32'hFFFF_FFFF;
      grav_settings[4] = $urandom >> $urandom_range(0, 31);
      foreach (grav_settings[ph]) begin
         write_gravity(grav_settings[ph]);
         for (int n = 0; n < 126; n++) pending_pairs.push_back(random_pair());
         wait_drained();
      end

      $display("checked %0d results from %0d pairs over seven constant phases",
               forces_checked, pairs_sent);
      $display("%0d saturated and %0d coincident cases seen, %0d mismatches", n_sat, n_coinc,
               mismatches);
      if (mismatches == 0 && expected_forces.size() == 0) begin
         $display("gravity_pair_force verification clean");
      end else begin
         $display("gravity_pair_force verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("gravity_pair_force verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/gpf_pkg.sv
rtl/gpf_mul_chain.sv
rtl/gpf_sqrt_chain.sv
rtl/gpf_div_chain.sv
rtl/gravity_pair_force.sv
tb/gravity_pair_force_test.sv
